// ===== src/vwtf_pkg.sv =====
package vwtf_pkg;

  localparam int VOLUME_W      = 32;
  localparam int FLOOR_W       = 32;
  localparam int RATIO_W       = 16;
  localparam int PERIOD_W      = 7;
  localparam int CFG_ADDR_W    = 2;
  localparam int CFG_DATA_W    = 32;
  localparam int OUT_DATA_W    = 8;

  localparam int DEF_MAX_PERIOD  = 64;
  localparam int DEF_VOLUME_BITS = 32;

  localparam logic [RATIO_W-1:0]  RATIO_RESET  = RATIO_W'(256);
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1);

  localparam logic [CFG_ADDR_W-1:0] CFG_VOL_FLOOR  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_RATIO      = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_LEN = 2'd2;

  // per-item verdict flags carried down the pipe
  typedef struct packed {
    logic abs_ok;     // absolute check result
    logic force_rel;  // relative check passes regardless (warming up or no history)
    logic warm;       // history shorter than the period after this bar
  } vwtf_flags_t;

endpackage

// ===== src/vwtf_ring.sv =====
module vwtf_ring #(
  parameter int DEPTH  = vwtf_pkg::DEF_MAX_PERIOD,
  parameter int DATA_W = vwtf_pkg::VOLUME_W,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);
  import vwtf_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] mem_q_r;
  logic [DATA_W-1:0] fwd_data_r;
  logic              fwd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r    <= mem[rd_addr];
      fwd_data_r <= wr_data;
    end
  end

  // same-cycle write to the entry being read: take the new value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (rd_en) begin
      fwd_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : mem_q_r;

endmodule

// ===== src/vwtf_cmp.sv =====
module vwtf_cmp #(
  parameter int VOL_W = vwtf_pkg::VOLUME_W,
  parameter int CNT_W = 7,
  parameter int SUM_W = 39
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          s_valid,
  output logic                          s_ready,
  input  logic [VOL_W-1:0]              s_vol,
  input  logic [CNT_W-1:0]              s_period,
  input  vwtf_pkg::vwtf_flags_t         s_flags,
  input  logic [SUM_W-1:0]              window_sum,
  input  logic [vwtf_pkg::RATIO_W-1:0]  ratio_q,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [vwtf_pkg::OUT_DATA_W-1:0] out_tdata
);
  import vwtf_pkg::*;

  localparam int RHS_W = SUM_W + RATIO_W;

  logic              s2_v_r;
  logic [VOL_W-1:0]  s2_vol_r;
  logic [CNT_W-1:0]  s2_p_r;
  vwtf_flags_t       s2_flags_r;

  logic              s3_v_r;
  logic [SUM_W-1:0]  s3_lhs_r;
  logic [RHS_W-1:0]  s3_rhs_r;
  logic              s3_force_r;
  vwtf_flags_t       s3_flags_r;

  logic              out_v_r;
  logic              out_abs_r;
  logic              out_rel_r;
  logic              out_warm_r;

  logic              en_out;
  logic              en3;
  logic              en2;
  logic [SUM_W-1:0]  lhs;
  logic [RHS_W-1:0]  rhs;
  logic              rel_ok;

  assign en_out  = !out_v_r || out_tready;
  assign en3     = !s3_v_r || en_out;
  assign en2     = !s2_v_r || en3;
  assign s_ready = en2;

  // window_sum already includes the bar held in this stage
  assign lhs = SUM_W'(s2_vol_r) * SUM_W'(s2_p_r);
  assign rhs = RHS_W'(ratio_q) * RHS_W'(window_sum);

  // volume*period*256 >= ratio*sum
  assign rel_ok = s3_force_r || (RHS_W'({s3_lhs_r, 8'h00}) >= s3_rhs_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (en2) s2_v_r <= s_valid;
      if (en3) s3_v_r <= s2_v_r;
      if (en_out) out_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_vol_r   <= s_vol;
      s2_p_r     <= s_period;
      s2_flags_r <= s_flags;
    end
    if (en3) begin
      s3_lhs_r   <= lhs;
      s3_rhs_r   <= rhs;
      s3_force_r <= s2_flags_r.force_rel || (window_sum == '0);
      s3_flags_r <= s2_flags_r;
    end
    if (en_out) begin
      out_abs_r  <= s3_flags_r.abs_ok;
      out_rel_r  <= rel_ok;
      out_warm_r <= s3_flags_r.warm;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'h0, out_warm_r, out_abs_r & out_rel_r, out_rel_r, out_abs_r};

`ifndef SYNTHESIS
  a_warm_passes_rel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_warm_r) |-> out_rel_r)
    else $error("warming-up result failed the relative check");
`endif

endmodule

// ===== src/volume_window_threshold_filter.sv =====
// Bar volume filter with an absolute floor and a moving-average ratio check.
//
// in_*  : one transaction per bar, in_tdata[31:0] = tick volume (unsigned).
// out_* : one transaction per bar, in input order:
//         bit 0 absolute pass, bit 1 relative pass, bit 2 both, bit 3 warming up.
// cfg_* : register writes, index 0 volume floor, 1 ratio (Q8.8),
//         2 window length. Writing the window length empties the window.
//         Write only while no transaction is in flight.
//
// A result passes registers s1, s2, s3 and the output register.
// Throughput: one bar per cycle while out_tready holds. The window sum is
// updated with one read and one write of the history RAM per bar; a
// back-to-back hit on the same entry is forwarded round the RAM.
// Reset: registers return to floor 0, ratio 1.0, length 1; the window is empty.
// The history RAM is not cleared; a fill count tracks valid entries.
// Back-pressure: each stage holds while the one after it is full and stalled,
// so in_tready drops only once the output and all stages are occupied.
module volume_window_threshold_filter #(
  parameter int MAX_PERIOD  = vwtf_pkg::DEF_MAX_PERIOD,
  parameter int VOLUME_BITS = vwtf_pkg::DEF_VOLUME_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [vwtf_pkg::VOLUME_W-1:0]     in_tdata,   // [31:0] bar volume
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [vwtf_pkg::OUT_DATA_W-1:0]   out_tdata,  // [0] pass_absolute,
                                                        // [1] pass_relative,
                                                        // [2] pass_both,
                                                        // [3] warming_up
  input  logic                              cfg_wr_en,
  input  logic [vwtf_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [vwtf_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);
  import vwtf_pkg::*;

  localparam int VOL_W  = (VOLUME_BITS < VOLUME_W) ? VOLUME_BITS : VOLUME_W;
  localparam int CNT_W  = $clog2(MAX_PERIOD + 1);
  localparam int ADDR_W = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
  localparam int SUM_W  = VOL_W + CNT_W;

  logic [FLOOR_W-1:0]  vol_floor_r;
  logic [RATIO_W-1:0]  ratio_r;
  logic [PERIOD_W-1:0] window_len_r;

  logic [CNT_W-1:0]  fill_r;
  logic [CNT_W-1:0]  fill_nxt;
  logic [ADDR_W-1:0] wp_r;
  logic [ADDR_W-1:0] wp_nxt;
  logic [SUM_W-1:0]  sum_r;
  logic [SUM_W-1:0]  sum_nxt;

  logic              s1_v_r;
  logic [VOL_W-1:0]  s1_vol_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic              s1_upd_r;
  logic              s1_sub_r;
  logic [CNT_W-1:0]  s1_p_r;
  vwtf_flags_t       s1_flags_r;

  logic [CNT_W-1:0]  eff_p;
  logic [VOL_W-1:0]  vol;
  logic              in_fire;
  logic              en0;
  logic              en1;
  logic              upd0;
  logic              sub0;
  logic              warm0;
  logic              abs0;
  logic              clr_hist;
  logic              ring_wr;
  logic [VOL_W-1:0]  ring_old;
  vwtf_flags_t       flags0;

  assign eff_p = (32'(window_len_r) > 32'(MAX_PERIOD)) ? CNT_W'(MAX_PERIOD)
                                                      : CNT_W'(window_len_r);
  assign vol      = in_tdata[VOL_W-1:0];
  assign en0      = !s1_v_r || en1;
  assign in_tready = en0;
  assign in_fire  = in_tvalid && en0;
  assign clr_hist = cfg_wr_en && (cfg_addr == CFG_WINDOW_LEN);

  // front stage: pointer and fill count move on acceptance
  always_comb begin
    upd0     = (eff_p != '0);
    sub0     = (fill_r >= eff_p);
    fill_nxt = sub0 ? fill_r : fill_r + CNT_W'(1);
    wp_nxt   = ((CNT_W + 1)'(wp_r) + (CNT_W + 1)'(1) >= (CNT_W + 1)'(eff_p))
               ? '0 : wp_r + ADDR_W'(1);
    warm0    = upd0 && (fill_nxt < eff_p);
    abs0     = (vol_floor_r == '0) || (FLOOR_W'(vol) >= vol_floor_r);
    flags0.abs_ok    = abs0;
    flags0.force_rel = !upd0 || warm0;
    flags0.warm      = warm0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vol_floor_r  <= '0;
      ratio_r      <= RATIO_RESET;
      window_len_r <= PERIOD_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_VOL_FLOOR:  vol_floor_r  <= cfg_wr_data[FLOOR_W-1:0];
        CFG_RATIO:      ratio_r      <= cfg_wr_data[RATIO_W-1:0];
        CFG_WINDOW_LEN: window_len_r <= cfg_wr_data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr_hist) begin
      fill_r <= '0;
      wp_r   <= '0;
    end else if (in_fire && upd0) begin
      fill_r <= fill_nxt;
      wp_r   <= wp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en0) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      s1_vol_r   <= vol;
      s1_addr_r  <= wp_r;
      s1_upd_r   <= upd0;
      s1_sub_r   <= sub0;
      s1_p_r     <= eff_p;
      s1_flags_r <= flags0;
    end
  end

  // second stage: drop the oldest bar once the window is full, add the new one
  assign ring_wr = s1_v_r && en1 && s1_upd_r;
  assign sum_nxt = sum_r - (s1_sub_r ? SUM_W'(ring_old) : '0) + SUM_W'(s1_vol_r);

  always_ff @(posedge clk) begin
    if (!rst_n || clr_hist) begin
      sum_r <= '0;
    end else if (ring_wr) begin
      sum_r <= sum_nxt;
    end
  end

  vwtf_ring #(
    .DEPTH  (MAX_PERIOD),
    .DATA_W (VOL_W),
    .ADDR_W (ADDR_W)
  ) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (ring_wr),
    .wr_addr (s1_addr_r),
    .wr_data (s1_vol_r),
    .rd_en   (en0),
    .rd_addr (wp_r),
    .rd_data (ring_old)
  );

  vwtf_cmp #(
    .VOL_W (VOL_W),
    .CNT_W (CNT_W),
    .SUM_W (SUM_W)
  ) u_cmp (
    .clk        (clk),
    .rst_n      (rst_n),
    .s_valid    (s1_v_r),
    .s_ready    (en1),
    .s_vol      (s1_vol_r),
    .s_period   (s1_p_r),
    .s_flags    (s1_flags_r),
    .window_sum (sum_r),
    .ratio_q    (ratio_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef SYNTHESIS
  a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= eff_p)
    else $error("fill count beyond window length");

  a_wp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (eff_p == '0) ? (wp_r == '0) : (CNT_W'(wp_r) < eff_p))
    else $error("write pointer outside window");

  a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == '0) |-> (sum_r == '0))
    else $error("window sum non-zero with empty history");
`endif

endmodule

// ===== sim/tb_volume_window_threshold_filter.sv =====
`timescale 1ns / 1ps

module tb_volume_window_threshold_filter;
  import vwtf_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 2'd3;
  localparam int HISTORY_DEPTH = DEF_MAX_PERIOD;
  localparam int BAR_TARGET    = 1250;
  localparam int CYCLE_LIMIT   = 500000;

  // out_tdata[3:0], lowest bit last
  typedef struct packed {
    logic warming_up;
    logic pass_both;
    logic pass_relative;
    logic pass_absolute;
  } verdict_t;

  class volume_verdict_model;
    logic [VOLUME_W-1:0]     history [HISTORY_DEPTH];
    logic [37:0]             window_total;
    int unsigned             bars_held;
    int unsigned             slot;
    logic [FLOOR_W-1:0]      floor_volume;
    logic [RATIO_W-1:0]      ratio_q88;
    logic [PERIOD_W-1:0]     period_reg;
    verdict_t                verdicts_due [$];
    int                      mismatch_count;
    int                      results_seen;

    function new();
      window_total   = '0;
      bars_held      = 0;
      slot           = 0;
      floor_volume   = '0;
      ratio_q88      = RATIO_RESET;
      period_reg     = PERIOD_RESET;
      mismatch_count = 0;
      results_seen   = 0;
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      unique case (idx)
        CFG_VOL_FLOOR: floor_volume = d[FLOOR_W-1:0];
        CFG_RATIO:     ratio_q88 = d[RATIO_W-1:0];
        CFG_WINDOW_LEN: begin
          // any period write empties the window, same value or not
          period_reg   = d[PERIOD_W-1:0];
          window_total = '0;
          bars_held    = 0;
          slot         = 0;
        end
        default: ;
      endcase
    endfunction

    function void note_input(logic [VOLUME_W-1:0] vol);
      int unsigned span;
      verdict_t    v;
      logic [63:0] scaled_vol;
      logic [63:0] scaled_sum;
      span = (period_reg > HISTORY_DEPTH) ? HISTORY_DEPTH : period_reg;
      if (span != 0) begin
        if (bars_held >= span) window_total -= 38'(history[slot]);
        history[slot] = vol;
        window_total += 38'(vol);
        slot = (slot + 1 >= span) ? 0 : slot + 1;
        if (bars_held < span) bars_held++;
      end
      v.warming_up    = (span != 0) && (bars_held < span);
      v.pass_absolute = (floor_volume == 0) || (vol >= floor_volume);
      if (span == 0 || v.warming_up || window_total == 0) begin
        v.pass_relative = 1'b1;
      end else begin
        // vol * period * 256 >= ratio * sum, both sides fit in 64 bits
        scaled_vol = 64'(vol) * 64'(span) * 64'd256;
        scaled_sum = 64'(ratio_q88) * 64'(window_total);
        v.pass_relative = scaled_vol >= scaled_sum;
      end
      v.pass_both = v.pass_absolute && v.pass_relative;
      verdicts_due.push_back(v);
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at result %0d: %s", results_seen, msg);
      mismatch_count++;
    endtask

    task compare_flag(string name, logic want, logic got);
      if (got !== want) report_mismatch($sformatf("%s expected %0b got %0b", name, want, got));
    endtask

    task check_result(logic [OUT_DATA_W-1:0] d);
      verdict_t want;
      verdict_t got;
      results_seen++;
      if (verdicts_due.size() == 0) begin
        report_mismatch($sformatf("result 0x%02h with none outstanding", d));
      end else begin
        want = verdicts_due.pop_front();
        got  = verdict_t'(d[3:0]);
        compare_flag("pass_absolute", want.pass_absolute, got.pass_absolute);
        compare_flag("pass_relative", want.pass_relative, got.pass_relative);
        compare_flag("pass_both", want.pass_both, got.pass_both);
        compare_flag("warming_up", want.warming_up, got.warming_up);
        if (d[OUT_DATA_W-1:4] !== '0)
          report_mismatch($sformatf("padding bits 0x%0h not zero", d[OUT_DATA_W-1:4]));
      end
    endtask
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [VOLUME_W-1:0]     in_tdata;
  logic                    out_tvalid;
  logic                    out_tready;
  logic [OUT_DATA_W-1:0]   out_tdata;
  logic                    cfg_wr_en;
  logic [CFG_ADDR_W-1:0]   cfg_addr;
  logic [CFG_DATA_W-1:0]   cfg_wr_data;

  volume_verdict_model model;
  bit                  in_burst;
  bit                  out_burst;
  int                  bars_sent;
  int                  cycle_count;

  always #10 clk = ~clk;

  volume_window_threshold_filter u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data)
  );

  // transaction monitors: values read here are the pre-edge ones
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) model.note_input(in_tdata);
      if (out_tvalid && out_tready) model.check_result(out_tdata);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side back-pressure
  initial begin : result_sink
    int stall;
    out_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = out_burst ? 0 : $urandom_range(0, 17);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_bar(input logic [VOLUME_W-1:0] vol);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= vol;
    do @(posedge clk); while (!in_tready);
    bars_sent++;
  endtask

  // hold off until every verdict is back, then let the pipe settle
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (model.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_wr_en   <= 1'b1;
    cfg_addr    <= idx;
    cfg_wr_data <= d;
    @(posedge clk);
    model.set_reg(idx, d);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [VOLUME_W-1:0] pick_volume(input logic [31:0] centre,
                                                     input bit zero_heavy);
    if (zero_heavy && $urandom_range(0, 3) != 0) return '0;
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return $urandom();
      default: return $urandom_range(0, {centre[30:0], 1'b1});
    endcase
  endfunction

  initial begin : stimulus
    logic [31:0]         centre;
    logic [CFG_DATA_W-1:0] wd;
    logic [PERIOD_W-1:0] period_now;
    int                  span;
    int                  n_bars;
    int                  pause_at;
    bit                  zero_heavy;

    model       = new();
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_addr    <= CFG_VOL_FLOOR;
    cfg_wr_data <= '0;
    in_burst    = 1'b1;
    out_burst   = 1'b1;
    bars_sent   = 0;
    cycle_count = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: period 1, ratio 1.0, no floor; zero sum passes
    send_bar(32'h0);
    send_bar(32'hFFFF_FFFF);
    send_bar(32'h1);
    drain_results();

    // period zero keeps no history; floor at its top
    write_reg(CFG_WINDOW_LEN, 32'h0);
    write_reg(CFG_VOL_FLOOR, 32'hFFFF_FFFF);
    write_reg(CFG_RATIO, 32'h0000_FFFF);
    send_bar(32'hFFFF_FFFF);
    send_bar(32'hFFFF_FFFE);
    send_bar(32'h0);
    drain_results();

    // ratio 2.0 over two bars, then a zero-sum window
    write_reg(CFG_WINDOW_LEN, 32'd2);
    write_reg(CFG_RATIO, 32'd512);
    write_reg(CFG_VOL_FLOOR, 32'd10);
    send_bar(32'd10);
    send_bar(32'd10);
    send_bar(32'd30);
    send_bar(32'd0);
    send_bar(32'd0);
    send_bar(32'd9);
    drain_results();

    // period past the ring depth saturates; junk above the period field
    write_reg(CFG_WINDOW_LEN, 32'hFFFF_FF7F);
    write_reg(CFG_RATIO, 32'h0);
    write_reg(CFG_VOL_FLOOR, 32'd1);
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    in_burst  = 1'b0;
    out_burst = 1'b0;
    send_bar(32'hFFFF_FFFF);
    send_bar(32'h0);
    send_bar(32'hFFFF_FFFF);
    drain_results();

    // full-scale window: equality passes, a zero bar then fails
    write_reg(CFG_WINDOW_LEN, 32'd3);
    write_reg(CFG_RATIO, 32'd256);
    write_reg(CFG_VOL_FLOOR, 32'h0);
    period_now = 7'd3;
    send_bar(32'hFFFF_FFFF);
    send_bar(32'hFFFF_FFFF);
    send_bar(32'hFFFF_FFFF);
    send_bar(32'h0);

    while (bars_sent < BAR_TARGET) begin
      drain_results();
      centre     = $urandom() >> $urandom_range(1, 31);
      zero_heavy = ($urandom_range(0, 7) == 0);
      in_burst   = ($urandom_range(0, 3) == 0);
      out_burst  = ($urandom_range(0, 3) == 0);

      if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: period_now = PERIOD_W'($urandom_range(1, 8));
          6:                period_now = PERIOD_W'($urandom_range(9, 64));
          7:                period_now = '0;
          8:                period_now = PERIOD_W'($urandom_range(65, 127));
          default:          period_now = $urandom_range(0, 1) ? 7'd64 : 7'd1;
        endcase
        wd = ($urandom_range(0, 3) == 0) ? $urandom() : '0;
        wd[PERIOD_W-1:0] = period_now;
        write_reg(CFG_WINDOW_LEN, wd);
      end
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: wd = $urandom_range(128, 512);
          5:             wd = 32'h0;
          6:             wd = 32'h0000_FFFF;
          default:       wd = $urandom_range(0, 65535);
        endcase
        if ($urandom_range(0, 3) == 0) wd[31:RATIO_W] = (CFG_DATA_W - RATIO_W)'($urandom());
        write_reg(CFG_RATIO, wd);
      end
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 5))
          0:       wd = 32'h0;
          1:       wd = 32'hFFFF_FFFF;
          2:       wd = $urandom();
          default: wd = $urandom_range(0, {centre[30:0], 1'b1});
        endcase
        write_reg(CFG_VOL_FLOOR, wd);
      end
      if ($urandom_range(0, 15) == 0) write_reg(CFG_UNUSED, $urandom());

      span     = (period_now > HISTORY_DEPTH) ? HISTORY_DEPTH : period_now;
      n_bars   = span + $urandom_range(10, 60);
      pause_at = $urandom_range(0, 3 * n_bars);
      for (int i = 0; i < n_bars; i++) begin
        if (i == pause_at) drain_results();
        send_bar(pick_volume(centre, zero_heavy));
      end
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (model.mismatch_count == 0 && model.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
